@@ hdl/twdrr_pkg.sv @@
`default_nettype none
package twdrr_pkg;

  // datapath sizing
  localparam int DEFICIT_BITS  = 24;
  localparam int SIZE_BITS     = 16;

  // fixed field widths
  localparam int HEAD_BITS     = 16;
  localparam int LIMIT_BITS    = 20;
  localparam int QUANTUM_BITS  = 16;
  localparam int WEIGHT_BITS   = 8;
  localparam int OVERHEAD_BITS = 8;
  localparam int CREDIT_BITS   = 24;
  localparam int GRANT_BITS    = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int PROD_BITS = QUANTUM_BITS + WEIGHT_BITS;
  localparam int SUM_BITS  = ((DEFICIT_BITS > PROD_BITS) ? DEFICIT_BITS : PROD_BITS) + 1;
  localparam int FIT_BITS  = LIMIT_BITS + 1;
  localparam int PASS_BITS = SIZE_BITS + 2;
  localparam int STEP_BITS = 3;

  // last pass index before the search gives up
  localparam logic [PASS_BITS-1:0] PASS_LAST = PASS_BITS'((64'd1 << SIZE_BITS) + 64'd1);
  localparam logic [DEFICIT_BITS-1:0] DEF_MAX = '1;

  localparam logic [QUANTUM_BITS-1:0]  QUANTUM_RESET  = QUANTUM_BITS'(1500);
  localparam logic [WEIGHT_BITS-1:0]   WEIGHT_RESET   = WEIGHT_BITS'(9);
  localparam logic [OVERHEAD_BITS-1:0] OVERHEAD_RESET = OVERHEAD_BITS'(38);

  typedef enum logic [GRANT_BITS-1:0] {
    GRANT_NONE    = 2'd0,
    GRANT_CLASSIC = 2'd1,
    GRANT_LL      = 2'd2
  } grant_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QUANTUM  = 2'd0,
    REG_WEIGHT   = 2'd1,
    REG_OVERHEAD = 2'd2
  } cfg_reg_t;

  // round flag bits
  localparam int RND_CL = 0;
  localparam int RND_LL = 1;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PROD,
    OP_ROUND,
    OP_LL,
    OP_CL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_START,
    COND_NO_ELIG,
    COND_LL_WIN,
    COND_CL_END,
    COND_OUT_FREE
  } cond_t;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_PROD  = 3'd1;
  localparam step_t STEP_ROUND = 3'd2;
  localparam step_t STEP_LL    = 3'd3;
  localparam step_t STEP_CL    = 3'd4;
  localparam step_t STEP_EMIT  = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t next;
  } ucode_t;

  typedef struct packed {
    logic [QUANTUM_BITS-1:0]  quantum;
    logic [WEIGHT_BITS-1:0]   weight;
    logic [OVERHEAD_BITS-1:0] overhead;
  } cfg_t;

  typedef struct packed {
    logic [HEAD_BITS-1:0]  ll_head;
    logic [HEAD_BITS-1:0]  cl_head;
    logic                  limit_enable;
    logic [LIMIT_BITS-1:0] byte_limit;
  } item_t;

  typedef struct packed {
    logic any_ok;
    logic ll_win;
    logic cl_win;
    logic cap_hit;
    logic out_free;
  } status_t;

  typedef struct packed {
    grant_t                 grant;
    logic [CREDIT_BITS-1:0] ll_credit;
    logic [CREDIT_BITS-1:0] cl_credit;
  } result_t;

  // control store: one word per step
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:  w = '{op: OP_IDLE,  cond: COND_START,    jump: STEP_PROD, next: STEP_IDLE};
      STEP_PROD:  w = '{op: OP_PROD,  cond: COND_NO_ELIG,  jump: STEP_EMIT, next: STEP_ROUND};
      STEP_ROUND: w = '{op: OP_ROUND, cond: COND_NONE,     jump: STEP_LL,   next: STEP_LL};
      STEP_LL:    w = '{op: OP_LL,    cond: COND_LL_WIN,   jump: STEP_EMIT, next: STEP_CL};
      STEP_CL:    w = '{op: OP_CL,    cond: COND_CL_END,   jump: STEP_EMIT, next: STEP_ROUND};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_FREE, jump: STEP_IDLE, next: STEP_EMIT};
      default:    w = '{op: OP_IDLE,  cond: COND_NONE,     jump: STEP_IDLE, next: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [DEFICIT_BITS-1:0] sat_add(logic [DEFICIT_BITS-1:0] a,
                                                      logic [PROD_BITS-1:0] b);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(a) + SUM_BITS'(b);
    return (s > SUM_BITS'(DEF_MAX)) ? DEF_MAX : DEFICIT_BITS'(s);
  endfunction

endpackage
`default_nettype wire

@@ hdl/twdrr_if.sv @@
`default_nettype none
interface twdrr_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] low_latency_head_bytes;
  logic [15:0] classic_head_bytes;
  logic        limit_enable;
  logic [19:0] byte_limit;

  modport source(output valid, low_latency_head_bytes, classic_head_bytes, limit_enable,
                 byte_limit, input ready);
  modport sink(input valid, low_latency_head_bytes, classic_head_bytes, limit_enable,
               byte_limit, output ready);
endinterface

interface twdrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  grant;
  logic [23:0] low_latency_credit;
  logic [23:0] classic_credit;

  modport source(output valid, grant, low_latency_credit, classic_credit, input ready);
  modport sink(input valid, grant, low_latency_credit, classic_credit, output ready);
endinterface

interface twdrr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/twdrr_useq.sv @@
`default_nettype none
module twdrr_useq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire twdrr_pkg::status_t status,
  output twdrr_pkg::op_t         op,
  output logic                   idle
);
  import twdrr_pkg::*;

  step_t  pc;
  step_t  pc_next;
  ucode_t uw;
  logic   cond_met;

  always_comb begin
    uw = ucode_rom(pc);
    unique case (uw.cond)
      COND_NONE:     cond_met = 1'b0;
      COND_START:    cond_met = start;
      COND_NO_ELIG:  cond_met = !status.any_ok;
      COND_LL_WIN:   cond_met = status.ll_win;
      COND_CL_END:   cond_met = status.cl_win || status.cap_hit;
      COND_OUT_FREE: cond_met = status.out_free;
      default:       cond_met = 1'b0;
    endcase
    pc_next = cond_met ? uw.jump : uw.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign op   = uw.op;
  assign idle = (uw.op == OP_IDLE);

endmodule
`default_nettype wire

@@ hdl/twdrr_dpath.sv @@
`default_nettype none
module twdrr_dpath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire twdrr_pkg::item_t   item,
  input  wire twdrr_pkg::cfg_t    cfg,
  input  wire twdrr_pkg::op_t     op,
  output twdrr_pkg::status_t      status,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output twdrr_pkg::result_t      rsp
);
  import twdrr_pkg::*;

  // item registers
  logic [SIZE_BITS-1:0]    ll_head;
  logic [SIZE_BITS-1:0]    cl_head;
  logic                    ll_ok;
  logic                    cl_ok;
  grant_t                  grant;
  logic [PROD_BITS-1:0]    prod;
  logic [PASS_BITS-1:0]    pass_cnt;

  // scheduler state
  logic [DEFICIT_BITS-1:0] ll_def;
  logic [DEFICIT_BITS-1:0] cl_def;
  logic [1:0]              round_active;

  logic [SIZE_BITS-1:0]    ll_in;
  logic [SIZE_BITS-1:0]    cl_in;
  logic                    ll_fit;
  logic                    cl_fit;
  logic                    ll_win;
  logic                    cl_win;
  logic                    out_free;

  always_comb begin
    ll_in  = SIZE_BITS'(item.ll_head);
    cl_in  = SIZE_BITS'(item.cl_head);
    ll_fit = (ll_in != '0) && (!item.limit_enable ||
             (FIT_BITS'(ll_in) + FIT_BITS'(cfg.overhead) <= FIT_BITS'(item.byte_limit)));
    cl_fit = (cl_in != '0) && (!item.limit_enable ||
             (FIT_BITS'(cl_in) + FIT_BITS'(cfg.overhead) <= FIT_BITS'(item.byte_limit)));
    ll_win   = ll_ok && (DEFICIT_BITS'(ll_head) <= ll_def);
    cl_win   = cl_ok && (DEFICIT_BITS'(cl_head) <= cl_def);
    out_free = !rsp_valid || rsp_ready;
    status = '{any_ok: ll_ok || cl_ok, ll_win: ll_win, cl_win: cl_win,
               cap_hit: pass_cnt == PASS_LAST, out_free: out_free};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ll_def       <= '0;
      cl_def       <= '0;
      round_active <= '0;
      rsp_valid    <= 1'b0;
      grant        <= GRANT_NONE;
      pass_cnt     <= '0;
    end else begin
      if (rsp_valid && rsp_ready && (op != OP_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (op)
        OP_IDLE: begin
          if (start) begin
            ll_head <= ll_in;
            cl_head <= cl_in;
            ll_ok   <= ll_fit;
            cl_ok   <= cl_fit;
            grant   <= GRANT_NONE;
          end
        end
        OP_PROD: begin
          prod     <= PROD_BITS'(cfg.quantum) * PROD_BITS'(cfg.weight);
          pass_cnt <= '0;
        end
        OP_ROUND: begin
          if (round_active == 2'b00) begin
            round_active <= 2'b11;
            ll_def       <= sat_add(ll_def, prod);
            cl_def       <= sat_add(cl_def, PROD_BITS'(cfg.quantum));
          end
        end
        OP_LL: begin
          if (ll_head == '0) begin
            ll_def               <= '0;
            round_active[RND_LL] <= 1'b0;
          end else if (ll_win) begin
            ll_def <= ll_def - DEFICIT_BITS'(ll_head);
            grant  <= GRANT_LL;
          end else begin
            round_active[RND_LL] <= 1'b0;
          end
        end
        OP_CL: begin
          if (cl_head == '0) begin
            cl_def               <= '0;
            round_active[RND_CL] <= 1'b0;
            pass_cnt             <= pass_cnt + PASS_BITS'(1);
          end else if (cl_win) begin
            cl_def <= cl_def - DEFICIT_BITS'(cl_head);
            grant  <= GRANT_CLASSIC;
          end else begin
            round_active[RND_CL] <= 1'b0;
            pass_cnt             <= pass_cnt + PASS_BITS'(1);
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            rsp.grant     <= grant;
            rsp.ll_credit <= CREDIT_BITS'(ll_def);
            rsp.cl_credit <= CREDIT_BITS'(cl_def);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/two_band_weighted_drr_scheduler.sv @@
// a request beat runs the product step, then round/ll/cl passes of the microcode loop
// (low-latency queue checked first, loop skipped when nothing is eligible) until a queue
// wins or the search gives up; the emit step registers the result once the output is free,
// and no new request is taken before that; at most 2^16 + 2 passes when quantum or weight is zero
// reset (synchronous, rst high): deficits and round flags cleared, registers to
// quantum 1500, weight 9, overhead 38; no clearing pass, requests taken at once
`default_nettype none
module two_band_weighted_drr_scheduler (
  input  wire logic  clk,
  input  wire logic  rst,
  twdrr_req_if.sink   req,
  twdrr_rsp_if.source rsp,
  twdrr_cfg_if.sink   cfg
);
  import twdrr_pkg::*;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  cfg_t    cfg_regs;

  item_t   item;
  status_t status;
  op_t     op;
  logic    idle;
  logic    start;
  result_t result;
  logic    rsp_valid;

  // config writes accepted out of reset; an unknown index is dropped
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.quantum  <= QUANTUM_RESET;
      cfg_regs.weight   <= WEIGHT_RESET;
      cfg_regs.overhead <= OVERHEAD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_QUANTUM:  cfg_regs.quantum  <= QUANTUM_BITS'(cfg.data);
        REG_WEIGHT:   cfg_regs.weight   <= WEIGHT_BITS'(cfg.data);
        REG_OVERHEAD: cfg_regs.overhead <= OVERHEAD_BITS'(cfg.data);
        default: begin
        end
      endcase
    end
  end

  // request beat taken only while the sequencer sits in its idle step, never in reset
  assign req.ready = idle && !rst;
  assign start     = req.valid && req.ready;

  always_comb begin
    item.ll_head      = req.low_latency_head_bytes;
    item.cl_head      = req.classic_head_bytes;
    item.limit_enable = req.limit_enable;
    item.byte_limit   = req.byte_limit;
  end

  // microcode sequencer: step counter and control store
  twdrr_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .idle   (idle)
  );

  // deficits, round flags, pass counter and result register
  twdrr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg       (cfg_regs),
    .op        (op),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp       (result)
  );

  // result beat
  assign rsp.valid              = rsp_valid;
  assign rsp.grant              = result.grant;
  assign rsp.low_latency_credit = result.ll_credit;
  assign rsp.classic_credit     = result.cl_credit;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twdrr_pkg::*;

  // holds the expected scheduler decisions and tracks deficits and round flags
  class grant_scoreboard;
    logic [QUANTUM_BITS-1:0]  quantum;
    logic [WEIGHT_BITS-1:0]   weight;
    logic [OVERHEAD_BITS-1:0] overhead;
    logic [DEFICIT_BITS-1:0]  ll_deficit;
    logic [DEFICIT_BITS-1:0]  cl_deficit;
    logic [1:0]               rounds_open;
    result_t                  expected_grants[$];
    int unsigned              errors;

    function new();
      quantum     = QUANTUM_RESET;
      weight      = WEIGHT_RESET;
      overhead    = OVERHEAD_RESET;
      ll_deficit  = '0;
      cl_deficit  = '0;
      rounds_open = 2'b00;
      errors      = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_QUANTUM:  quantum  = value[QUANTUM_BITS-1:0];
        REG_WEIGHT:   weight   = value[WEIGHT_BITS-1:0];
        REG_OVERHEAD: overhead = value[OVERHEAD_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction

    // non-empty head and, with the limit on, framed size within the budget
    function bit admitted(logic [SIZE_BITS-1:0] head, item_t it);
      if (head == '0) return 1'b0;
      if (!it.limit_enable) return 1'b1;
      return (int'(head) + int'(overhead)) <= int'(it.byte_limit);
    endfunction

    function logic [DEFICIT_BITS-1:0] credit_add(logic [DEFICIT_BITS-1:0] d,
                                                 longint unsigned inc);
      longint unsigned sum;
      longint unsigned ceiling;
      ceiling = (64'd1 << DEFICIT_BITS) - 1;
      sum = d;
      sum = sum + inc;
      return (sum > ceiling) ? DEFICIT_BITS'(ceiling) : DEFICIT_BITS'(sum);
    endfunction

    // one request beat taken: run the round search and queue its decision
    function void note_request(item_t it);
      logic [SIZE_BITS-1:0] ll;
      logic [SIZE_BITS-1:0] cl;
      bit                   ll_ok;
      bit                   cl_ok;
      grant_t               g;
      result_t              want;
      longint unsigned      pass_cap;
      longint unsigned      pass;
      longint unsigned      ll_quota;
      ll       = it.ll_head[SIZE_BITS-1:0];
      cl       = it.cl_head[SIZE_BITS-1:0];
      ll_ok    = admitted(ll, it);
      cl_ok    = admitted(cl, it);
      g        = GRANT_NONE;
      pass_cap = (64'd1 << SIZE_BITS) + 2;
      ll_quota = longint'(quantum) * longint'(weight);
      if (ll_ok || cl_ok) begin
        for (pass = 0; pass < pass_cap && g == GRANT_NONE; pass++) begin
          if (rounds_open == 2'b00) begin
            rounds_open = 2'b11;
            ll_deficit  = credit_add(ll_deficit, ll_quota);
            cl_deficit  = credit_add(cl_deficit, longint'(quantum));
          end
          if (ll == '0) begin
            ll_deficit = '0;
            rounds_open[RND_LL] = 1'b0;
          end else if (ll_ok && ll <= ll_deficit) begin
            ll_deficit = ll_deficit - ll;
            g = GRANT_LL;
            break;
          end else begin
            rounds_open[RND_LL] = 1'b0;
          end
          if (cl == '0) begin
            cl_deficit = '0;
            rounds_open[RND_CL] = 1'b0;
          end else if (cl_ok && cl <= cl_deficit) begin
            cl_deficit = cl_deficit - cl;
            g = GRANT_CLASSIC;
            break;
          end else begin
            rounds_open[RND_CL] = 1'b0;
          end
        end
      end
      want.grant     = g;
      want.ll_credit = CREDIT_BITS'(ll_deficit);
      want.cl_credit = CREDIT_BITS'(cl_deficit);
      expected_grants = {expected_grants, want};
    endfunction

    function void check_grant(result_t got);
      result_t want;
      if (expected_grants.size() == 0) begin
        $error("result beat with nothing expected: grant %0d ll %0d cl %0d",
               got.grant, got.ll_credit, got.cl_credit);
        errors++;
        return;
      end
      want = expected_grants[0];
      expected_grants.delete(0);
      if (got.grant !== want.grant) begin
        $error("grant: expected %0d, got %0d", want.grant, got.grant);
        errors++;
      end
      if (got.ll_credit !== want.ll_credit) begin
        $error("low_latency_credit: expected %0d, got %0d", want.ll_credit, got.ll_credit);
        errors++;
      end
      if (got.cl_credit !== want.cl_credit) begin
        $error("classic_credit: expected %0d, got %0d", want.cl_credit, got.cl_credit);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  twdrr_req_if req_bus ();
  twdrr_rsp_if rsp_bus ();
  twdrr_cfg_if cfg_bus ();

  two_band_weighted_drr_scheduler u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  grant_scoreboard sb = new();

  // percent chance per cycle that the sender holds off / the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;

  always #6 clk = ~clk;

  // receiver side: ready toggles at random while a stall mode is active
  always @(posedge clk) begin
    rsp_bus.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
  end

  // every result beat is checked against the oldest queued decision
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got.grant     = grant_t'(rsp_bus.grant);
      got.ll_credit = rsp_bus.low_latency_credit;
      got.cl_credit = rsp_bus.classic_credit;
      sb.check_grant(got);
    end
  end

  function automatic item_t make_request(int unsigned ll, int unsigned cl, bit en,
                                         int unsigned lim);
    item_t it;
    it.ll_head      = HEAD_BITS'(ll);
    it.cl_head      = HEAD_BITS'(cl);
    it.limit_enable = en;
    it.byte_limit   = LIMIT_BITS'(lim);
    return it;
  endfunction

  // head sizes scaled to the credit one round brings, so few passes are needed;
  // the full 16-bit range only where a round credits at least 2 KB
  function automatic logic [HEAD_BITS-1:0] random_head(longint unsigned per_round);
    longint unsigned cap;
    int unsigned     roll;
    roll = $urandom_range(99);
    cap  = (per_round * 3 > 65535) ? 65535 : per_round * 3;
    if (roll < 12) return '0;
    if (roll < 24 && per_round >= 2048) return HEAD_BITS'($urandom_range(65535, 1));
    return HEAD_BITS'($urandom_range(int'(cap), 1));
  endfunction

  function automatic item_t random_request();
    item_t it;
    int    target;
    int    lim;
    it.ll_head      = random_head(longint'(sb.quantum) * longint'(sb.weight));
    it.cl_head      = random_head(longint'(sb.quantum));
    it.limit_enable = ($urandom_range(99) < 60);
    if ($urandom_range(99) < 55) begin
      // budget right around one framed head, so the fit test flips both ways
      target = ($urandom_range(1) != 0) ? int'(it.ll_head) : int'(it.cl_head);
      lim    = target + int'(sb.overhead) + int'($urandom_range(6)) - 3;
      if (lim < 0) lim = 0;
    end else begin
      lim = int'($urandom_range(20'hFFFFF, 0));
    end
    it.byte_limit = LIMIT_BITS'(lim);
    return it;
  endfunction

  // leaves valid high after the beat so back-to-back requests need no extra edge
  task automatic push_request(input item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid                  <= 1'b1;
    req_bus.low_latency_head_bytes <= it.ll_head;
    req_bus.classic_head_bytes     <= it.cl_head;
    req_bus.limit_enable           <= it.limit_enable;
    req_bus.byte_limit             <= it.byte_limit;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    sb.note_request(it);
  endtask

  // sender holds off until every queued decision has come back
  task automatic drain_requests();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // writes all three registers; only called with the block idle
  task automatic write_config(input logic [15:0] q, input logic [15:0] w,
                              input logic [15:0] o);
    logic [CFG_DATA_BITS-1:0] vals [3];
    cfg_reg_t                 regs [3];
    vals = '{q, w, o};
    regs = '{REG_QUANTUM, REG_WEIGHT, REG_OVERHEAD};
    for (int i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= regs[i];
      cfg_bus.data  <= vals[i];
      do @(posedge clk); while (cfg_bus.ready !== 1'b1);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] q;
    logic [15:0] w;
    logic [15:0] o;
    // every block input known from time zero
    req_bus.valid                  = 1'b0;
    req_bus.low_latency_head_bytes = '0;
    req_bus.classic_head_bytes     = '0;
    req_bus.limit_enable           = 1'b0;
    req_bus.byte_limit             = '0;
    rsp_bus.ready                  = 1'b0;
    cfg_bus.valid                  = 1'b0;
    cfg_bus.index                  = REG_QUANTUM;
    cfg_bus.data                   = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: quantum 1500, weight 9, overhead 38
    push_request(make_request(0, 0, 0, 0));             // both queues empty
    push_request(make_request(0, 0, 1, 20'hFFFFF));     // empty under max budget
    push_request(make_request(100, 0, 0, 0));           // first round, low-latency wins
    push_request(make_request(0, 200, 0, 0));           // empty ll zeroes its deficit
    push_request(make_request(1500, 1500, 0, 0));
    push_request(make_request(1000, 1000, 1, 1038));    // framed head fits exactly
    push_request(make_request(1000, 1000, 1, 1037));    // one byte short: nothing eligible
    push_request(make_request(2000, 500, 1, 600));      // ll blocked by limit, deficit kept
    push_request(make_request(500, 2000, 1, 600));      // classic blocked by limit
    push_request(make_request(65535, 0, 0, 0));         // several rounds for a big ll head
    push_request(make_request(0, 65535, 0, 0));         // many rounds for a big classic head
    push_request(make_request(40000, 30000, 1, 20'hFFFFF));
    push_request(make_request(1, 1, 0, 20'hFFFFF));
    drain_requests();

    // largest settings: ll deficit saturates while its head stays over the limit
    write_config(16'hFFFF, 16'd255, 16'd255);
    push_request(make_request(65535, 65535, 0, 0));
    repeat (4) push_request(make_request(65535, 65000, 1, 65255));
    push_request(make_request(65535, 65535, 1, 20'hFFFFF));
    drain_requests();

    // smallest settings: one byte of credit per round
    write_config(16'd1, 16'd1, 16'd0);
    push_request(make_request(1, 0, 1, 1));             // fit with zero overhead
    push_request(make_request(3, 5, 0, 0));
    push_request(make_request(0, 1, 1, 0));             // zero budget blocks everything
    push_request(make_request(20, 20, 0, 0));
    drain_requests();

    // random: 14 bursts, each with its own settings and idle mode
    for (int burst = 0; burst < 14; burst++) begin
      case (burst)
        0: begin q = 16'd1500;  w = 16'd9;   o = 16'd38;  end
        1: begin q = 16'hFFFF;  w = 16'd255; o = 16'd255; end
        2: begin q = 16'd1;     w = 16'd1;   o = 16'd0;   end
        3: begin q = 16'd1;     w = 16'd255; o = 16'd255; end
        4: begin q = 16'hFFFF;  w = 16'd1;   o = 16'd0;   end
        default: begin
          q = ($urandom_range(1) != 0) ? 16'($urandom_range(65535, 1))
                                       : 16'($urandom_range(3000, 1));
          w = 16'($urandom_range(255, 1));
          o = 16'($urandom_range(255, 0));
        end
      endcase
      write_config(q, w, o);
      case (burst % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
        default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
      endcase
      repeat (125) push_request(random_request());
      drain_requests();
    end

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    // let the bench settle so a stray extra result beat would still be caught
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #24ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
